// ===== rtl/core/pssd_pkg.sv =====
package pssd_pkg;

   localparam int PIX_W        = 8;
   localparam int COORD_W      = 10;
   localparam int COST_W       = 31;
   localparam int SIDE_CSR_W   = 5;
   localparam int FRAMES_CSR_W = 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 5;
   localparam int SQ_W         = 2 * PIX_W;
   // Three squared differences of 16 bits each fit in 18 bits.
   localparam int ADD_W        = SQ_W + 2;
   localparam int NUM_PIX_CH   = 3;

   localparam logic [COST_W-1:0]       COST_MAX     = {COST_W{1'b1}};
   localparam logic [SIDE_CSR_W-1:0]   SIDE_RESET   = SIDE_CSR_W'(5);
   localparam logic [FRAMES_CSR_W-1:0] FRAMES_RESET = FRAMES_CSR_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATCH_SIDE   = 1'b0,
      CSR_PATCH_FRAMES = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_VOXEL = 1'b1
   } func_type;

   typedef struct packed {
      func_type             func;
      logic [PIX_W-1:0]     a_red;
      logic [PIX_W-1:0]     a_green;
      logic [PIX_W-1:0]     a_blue;
      logic [PIX_W-1:0]     b_red;
      logic [PIX_W-1:0]     b_green;
      logic [PIX_W-1:0]     b_blue;
      logic [COORD_W-1:0]   cand_row;
      logic [COORD_W-1:0]   cand_col;
      logic [COORD_W-1:0]   cand_frame;
      logic [COST_W-1:0]    init_cost;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0]   best_row;
      logic [COORD_W-1:0]   best_col;
      logic [COORD_W-1:0]   best_frame;
      logic [COST_W-1:0]    best_score;
      logic [COST_W-1:0]    cand_score;
      logic                 improved;
      logic                 cut_short;
   } rsp_payload_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

// ===== rtl/core/pssd_stream_if.sv =====
interface pssd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pssd_csr_if.sv =====
interface pssd_csr_if;
   logic                                valid;
   logic                                ready;
   pssd_pkg::csr_index_type             index;
   logic [pssd_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/patch_ssd_best_match_update_unit.sv =====
// Scores candidate patches by the sum of squared differences against one
// target patch and keeps the best match. The block takes one request per
// clock cycle without gaps while no pending result is held off by the result
// side: stage one squares and sums the channel differences of a voxel pair,
// stage two updates the running cost, the row and patch counters and the best
// match. The last voxel of a candidate is registered in stage one, and its
// result is written to the result register when stage two fires. Load requests
// and voxels that do not end a candidate give no result. Configuration writes
// are always taken and must only be made while no candidate is in flight.
module patch_ssd_best_match_update_unit #(
   parameter int MAX_SIDE   = 16,
   parameter int MAX_FRAMES = 8,
   parameter int CHANNELS   = 3
) (
   input  logic          clock,
   input  logic          reset,
   pssd_stream_if.sink   req_ch,
   pssd_stream_if.source rsp_ch,
   pssd_csr_if.sink      csr_ch
);

   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
   localparam int FRM_W    = $clog2(MAX_FRAMES + 1);
   localparam int ROWS_MAX = MAX_SIDE * MAX_FRAMES;
   localparam int ROW_W    = $clog2(ROWS_MAX + 1);
   localparam int COST_W   = pssd_pkg::COST_W;
   localparam int COORD_W  = pssd_pkg::COORD_W;
   localparam int ADD_W    = pssd_pkg::ADD_W;

   // Configuration registers.
   logic [pssd_pkg::SIDE_CSR_W-1:0]   side_ff, side_in;
   logic [pssd_pkg::FRAMES_CSR_W-1:0] frames_ff, frames_in;

   // Stage one: voxel pair reduced to its cost contribution.
   logic                   s1_valid_ff, s1_valid_in;
   pssd_pkg::func_type     s1_func_ff;
   logic [ADD_W-1:0]       s1_add_ff, s1_add_in;
   logic [COORD_W-1:0]     s1_row_ff, s1_col_ff, s1_frame_ff;
   logic [COST_W-1:0]      s1_cost_ff;

   // Stage two: accumulator and best match.
   logic [COST_W-1:0]      sum_ff, sum_in;
   logic [SIDE_W-1:0]      vir_ff, vir_in;
   logic [ROW_W-1:0]       row_cnt_ff, row_cnt_in;
   logic                   stopped_ff, stopped_in;
   logic [COST_W-1:0]      best_cost_ff, best_cost_in;
   logic [COORD_W-1:0]     best_row_ff, best_row_in;
   logic [COORD_W-1:0]     best_col_ff, best_col_in;
   logic [COORD_W-1:0]     best_frame_ff, best_frame_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   pssd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   s2_fire;
   logic                   emit;
   logic [SIDE_W-1:0]      side_eff;
   logic [FRM_W-1:0]       frames_eff;
   logic [ROW_W-1:0]       rows_eff;
   logic [COST_W:0]        sum_wide;
   logic [COST_W-1:0]      sum_acc;
   logic                   row_end;
   logic                   last_row;
   logic                   stop_now;
   logic [COST_W-1:0]      sum_row;
   logic                   stopped_row;

   assign s2_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_fire;
   assign req_accept = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Configuration writes.
   always_comb begin
      side_in   = side_ff;
      frames_in = frames_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pssd_pkg::CSR_PATCH_SIDE:   side_in   = csr_ch.data;
            pssd_pkg::CSR_PATCH_FRAMES: frames_in = csr_ch.data[pssd_pkg::FRAMES_CSR_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one and values above the maximum are clamped.
   always_comb begin
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (int'(side_ff) > MAX_SIDE) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = SIDE_W'(side_ff);
      end
      if (frames_ff == '0) begin
         frames_eff = FRM_W'(1);
      end else if (int'(frames_ff) > MAX_FRAMES) begin
         frames_eff = FRM_W'(MAX_FRAMES);
      end else begin
         frames_eff = FRM_W'(frames_ff);
      end
      rows_eff = ROW_W'(int'(side_eff) * int'(frames_eff));
   end

   // Stage one arithmetic.
   always_comb begin
      logic [pssd_pkg::PIX_W-1:0] a_pix [pssd_pkg::NUM_PIX_CH];
      logic [pssd_pkg::PIX_W-1:0] b_pix [pssd_pkg::NUM_PIX_CH];
      a_pix[0] = req_ch.data.a_red;
      a_pix[1] = req_ch.data.a_green;
      a_pix[2] = req_ch.data.a_blue;
      b_pix[0] = req_ch.data.b_red;
      b_pix[1] = req_ch.data.b_green;
      b_pix[2] = req_ch.data.b_blue;
      s1_add_in = '0;
      for (int ch = 0; ch < pssd_pkg::NUM_PIX_CH; ch++) begin
         if (ch < CHANNELS) begin
            s1_add_in = s1_add_in + ADD_W'(pssd_pkg::sq_diff(a_pix[ch], b_pix[ch]));
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Stage two: accumulate, test at row ends, decide at the candidate end.
   always_comb begin
      sum_wide    = {1'b0, sum_ff} + (COST_W + 1)'(s1_add_ff);
      sum_acc     = stopped_ff ? sum_ff
                  : (sum_wide[COST_W] ? pssd_pkg::COST_MAX : sum_wide[COST_W-1:0]);
      row_end     = ((SIDE_W + 1)'(vir_ff) + (SIDE_W + 1)'(1)) >= (SIDE_W + 1)'(side_eff);
      last_row    = ((ROW_W + 1)'(row_cnt_ff) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(rows_eff);
      stop_now    = !stopped_ff && (sum_acc >= best_cost_ff);
      sum_row     = stop_now ? best_cost_ff : sum_acc;
      stopped_row = stopped_ff || stop_now;

      sum_in        = sum_ff;
      vir_in        = vir_ff;
      row_cnt_in    = row_cnt_ff;
      stopped_in    = stopped_ff;
      best_cost_in  = best_cost_ff;
      best_row_in   = best_row_ff;
      best_col_in   = best_col_ff;
      best_frame_in = best_frame_ff;
      emit          = 1'b0;
      rsp_data_in   = rsp_data_ff;

      if (s2_fire) begin
         if (s1_func_ff == pssd_pkg::FUNC_LOAD) begin
            best_cost_in  = s1_cost_ff;
            best_row_in   = s1_row_ff;
            best_col_in   = s1_col_ff;
            best_frame_in = s1_frame_ff;
            sum_in        = '0;
            vir_in        = '0;
            row_cnt_in    = '0;
            stopped_in    = 1'b0;
         end else if (!row_end) begin
            sum_in = sum_acc;
            vir_in = vir_ff + SIDE_W'(1);
         end else if (!last_row) begin
            sum_in     = sum_row;
            vir_in     = '0;
            row_cnt_in = row_cnt_ff + ROW_W'(1);
            stopped_in = stopped_row;
         end else begin
            // A stopped candidate holds exactly the best cost, so it never
            // improves; an unstopped one is strictly below the best cost.
            emit = 1'b1;
            if (!stopped_row) begin
               best_cost_in  = sum_row;
               best_row_in   = s1_row_ff;
               best_col_in   = s1_col_ff;
               best_frame_in = s1_frame_ff;
            end
            rsp_data_in.best_row   = best_row_in;
            rsp_data_in.best_col   = best_col_in;
            rsp_data_in.best_frame = best_frame_in;
            rsp_data_in.best_score = best_cost_in;
            rsp_data_in.cand_score = sum_row;
            rsp_data_in.improved   = !stopped_row;
            rsp_data_in.cut_short  = stopped_row;
            sum_in     = '0;
            vir_in     = '0;
            row_cnt_in = '0;
            stopped_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= pssd_pkg::SIDE_RESET;
         frames_ff     <= pssd_pkg::FRAMES_RESET;
         s1_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         vir_ff        <= '0;
         row_cnt_ff    <= '0;
         stopped_ff    <= 1'b0;
         best_cost_ff  <= pssd_pkg::COST_MAX;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
         best_frame_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         side_ff       <= side_in;
         frames_ff     <= frames_in;
         s1_valid_ff   <= s1_valid_in;
         sum_ff        <= sum_in;
         vir_ff        <= vir_in;
         row_cnt_ff    <= row_cnt_in;
         stopped_ff    <= stopped_in;
         best_cost_ff  <= best_cost_in;
         best_row_ff   <= best_row_in;
         best_col_ff   <= best_col_in;
         best_frame_ff <= best_frame_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_func_ff  <= req_ch.data.func;
         s1_add_ff   <= s1_add_in;
         s1_row_ff   <= req_ch.data.cand_row;
         s1_col_ff   <= req_ch.data.cand_col;
         s1_frame_ff <= req_ch.data.cand_frame;
         s1_cost_ff  <= req_ch.data.init_cost;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // A stopped candidate has its sum clamped to the best cost.
   a_stopped_clamped: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> sum_ff == best_cost_ff)
      else $error("stopped candidate sum differs from best cost");

   // An improving candidate becomes the best cost.
   a_improved_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.improved |->
         rsp_data_ff.best_score == rsp_data_ff.cand_score)
      else $error("improved result with mismatched scores");

   // The best cost never exceeds the candidate cost in a result.
   a_best_not_worse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.cand_score >= rsp_data_ff.best_score)
      else $error("best score above candidate score");

   // A candidate cut short can not replace the best match.
   a_cut_not_improved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.cut_short |-> !rsp_data_ff.improved)
      else $error("cut short candidate marked improved");

   // A new result is only produced when the result register is free or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

// ===== tb/sv/best_match_checker.sv =====
module best_match_checker
   import pssd_pkg::*;
#(
   parameter int MAX_SIDE   = 16,
   parameter int MAX_FRAMES = 8,
   parameter int CHANNELS   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    matches_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SIDE_CSR_W-1:0]   side_cfg;
   logic [FRAMES_CSR_W-1:0] frames_cfg;

   logic [COST_W-1:0]  running_cost;
   logic [3:0]         voxel_idx;
   logic [7:0]         row_idx;
   logic               halted;
   logic [COST_W-1:0]  best_cost;
   logic [COORD_W-1:0] best_row;
   logic [COORD_W-1:0] best_col;
   logic [COORD_W-1:0] best_frame;

   rsp_payload_type match_q[$];
   rsp_payload_type want;
   rsp_payload_type scored;
   int              errors;

   function automatic int unsigned clip_dim(input int unsigned v, input int unsigned top_v);
      if (v == 0) return 1;
      if (v > top_v) return top_v;
      return v;
   endfunction

   function automatic void restart_candidate();
      running_cost = '0;
      voxel_idx    = '0;
      row_idx      = '0;
      halted       = 1'b0;
   endfunction

   // Advances the scoring state by one request and reports whether it closes
   // a candidate, in which case res holds the match update.
   function automatic bit score_voxel(input req_payload_type r, output rsp_payload_type res);
      int unsigned      side;
      int unsigned      rows;
      int               ch;
      logic [PIX_W-1:0] av [3];
      logic [PIX_W-1:0] bv [3];
      logic [PIX_W-1:0] diff;
      logic [31:0]      add;
      logic [31:0]      total;
      logic [COST_W-1:0] cost;
      bit               gain;
      res  = '0;
      side = clip_dim(side_cfg, MAX_SIDE);
      rows = side * clip_dim(frames_cfg, MAX_FRAMES);
      if (r.func == FUNC_LOAD) begin
         best_row   = r.cand_row;
         best_col   = r.cand_col;
         best_frame = r.cand_frame;
         best_cost  = r.init_cost;
         restart_candidate();
         return 1'b0;
      end
      if (!halted) begin
         av  = '{r.a_red, r.a_green, r.a_blue};
         bv  = '{r.b_red, r.b_green, r.b_blue};
         add = '0;
         for (ch = 0; ch < CHANNELS && ch < NUM_PIX_CH; ch++) begin
            diff = (av[ch] > bv[ch]) ? av[ch] - bv[ch] : bv[ch] - av[ch];
            add += 32'(diff) * 32'(diff);
         end
         total = 32'(running_cost) + add;
         running_cost = (total > 32'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];
      end
      if (voxel_idx + 1 < side) begin
         voxel_idx++;
         return 1'b0;
      end
      // Row boundary: give up on this candidate once it can no longer win.
      voxel_idx = '0;
      if (!halted && running_cost >= best_cost) begin
         halted       = 1'b1;
         running_cost = best_cost;
      end
      if (row_idx + 1 < rows) begin
         row_idx++;
         return 1'b0;
      end
      cost = running_cost;
      gain = (cost < best_cost);
      if (gain) begin
         best_cost  = cost;
         best_row   = r.cand_row;
         best_col   = r.cand_col;
         best_frame = r.cand_frame;
      end
      res.best_row   = best_row;
      res.best_col   = best_col;
      res.best_frame = best_frame;
      res.best_score = best_cost;
      res.cand_score = cost;
      res.improved   = gain;
      res.cut_short  = halted;
      restart_candidate();
      return 1'b1;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         if (errors < 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         side_cfg   = SIDE_RESET;
         frames_cfg = FRAMES_RESET;
         restart_candidate();
         best_cost  = COST_MAX;
         best_row   = '0;
         best_col   = '0;
         best_frame = '0;
         match_q.delete();
         errors     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATCH_SIDE:   side_cfg   = csr_data[SIDE_CSR_W-1:0];
               CSR_PATCH_FRAMES: frames_cfg = csr_data[FRAMES_CSR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (match_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: best_score %0d, cand_score %0d",
                           rsp_data.best_score, rsp_data.cand_score);
               errors++;
            end else begin
               want = match_q.pop_front();
               check_field("best_row", want.best_row, rsp_data.best_row);
               check_field("best_col", want.best_col, rsp_data.best_col);
               check_field("best_frame", want.best_frame, rsp_data.best_frame);
               check_field("best_score", want.best_score, rsp_data.best_score);
               check_field("cand_score", want.cand_score, rsp_data.cand_score);
               check_field("improved", want.improved, rsp_data.improved);
               check_field("cut_short", want.cut_short, rsp_data.cut_short);
            end
         end
         if (req_valid && req_ready) begin
            if (score_voxel(req_data, scored)) match_q.push_back(scored);
         end
      end
      mismatch_count  <= errors;
      matches_pending <= match_q.size();
   end

endmodule

// ===== tb/sv/tb_patch_ssd_best_match_update_unit.sv =====
module tb_patch_ssd_best_match_update_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pssd_pkg::*;

   localparam int MAX_SIDE     = 16;
   localparam int MAX_FRAMES   = 8;
   localparam int CHANNELS     = 3;
   localparam int GAP_MAX      = 5;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 200;
   localparam int ITEM_TARGET  = 1850;

   typedef enum int {
      PIX_SAME,
      PIX_NEAR,
      PIX_EXTREME,
      PIX_RANDOM
   } pixel_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   matches_pending;
   bit   no_idle = 1'b0;
   int   hold_requests = 0;
   int   holds_done = 0;
   int   items_sent = 0;

   pssd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   pssd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   pssd_csr_if csr_ch ();

   patch_ssd_best_match_update_unit #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_FRAMES (MAX_FRAMES),
      .CHANNELS   (CHANNELS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   best_match_checker #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_FRAMES (MAX_FRAMES),
      .CHANNELS   (CHANNELS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_data        (req_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_data        (rsp_ch.data),
      .csr_valid       (csr_ch.valid),
      .csr_ready       (csr_ch.ready),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .mismatch_count  (mismatch_count),
      .matches_pending (matches_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when requested.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            stall = HOLD_CYCLES;
            holds_done++;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   function automatic req_payload_type make_voxel(input pixel_mode_type mode);
      req_payload_type  item;
      logic [PIX_W-1:0] a [3];
      logic [PIX_W-1:0] b [3];
      int               nudge;
      int               ch;
      item.func       = FUNC_VOXEL;
      item.cand_row   = COORD_W'($urandom);
      item.cand_col   = COORD_W'($urandom);
      item.cand_frame = COORD_W'($urandom);
      item.init_cost  = COST_W'($urandom);
      for (ch = 0; ch < 3; ch++) begin
         a[ch] = PIX_W'($urandom);
         case (mode)
            PIX_SAME: b[ch] = a[ch];
            PIX_NEAR: begin
               nudge = int'(a[ch]) + int'($urandom_range(0, 6)) - 3;
               if (nudge < 0) nudge = 0;
               if (nudge > 255) nudge = 255;
               b[ch] = PIX_W'(nudge);
            end
            PIX_EXTREME: begin
               a[ch] = $urandom_range(0, 1) ? '1 : '0;
               b[ch] = $urandom_range(0, 1) ? ~a[ch] : a[ch];
            end
            default: b[ch] = PIX_W'($urandom);
         endcase
      end
      item.a_red   = a[0];
      item.a_green = a[1];
      item.a_blue  = a[2];
      item.b_red   = b[0];
      item.b_green = b[1];
      item.b_blue  = b[2];
      return item;
   endfunction

   // Same target and candidate value on every channel.
   function automatic req_payload_type flat_voxel(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      req_payload_type item;
      item         = make_voxel(PIX_RANDOM);
      item.a_red   = a;
      item.a_green = a;
      item.a_blue  = a;
      item.b_red   = b;
      item.b_green = b;
      item.b_blue  = b;
      return item;
   endfunction

   function automatic req_payload_type make_load(input logic [COST_W-1:0] cost);
      req_payload_type item;
      item           = make_voxel(PIX_RANDOM);
      item.func      = FUNC_LOAD;
      item.init_cost = cost;
      return item;
   endfunction

   function automatic logic [COST_W-1:0] pick_cost(input int patch_len);
      case ($urandom_range(0, 3))
         0:       return COST_MAX;
         1:       return COST_W'($urandom);
         2:       return COST_W'($urandom_range(0, patch_len * 40));
         default: return COST_W'($urandom_range(patch_len * 200, patch_len * 30000));
      endcase
   endfunction

   task automatic send_item(input req_payload_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   // Stops offering requests until every match update is back and the
   // pipeline has flushed any voxels that give no result.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (matches_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reshape(input logic [CSR_DATA_W-1:0] side_d,
                          input logic [CSR_DATA_W-1:0] frames_d);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_PATCH_SIDE;
      csr_ch.data  <= side_d;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.index <= CSR_PATCH_FRAMES;
      csr_ch.data  <= frames_d;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      req_payload_type       item;
      logic [CSR_DATA_W-1:0] side_d;
      logic [CSR_DATA_W-1:0] frames_d;
      pixel_mode_type        mode;
      int                    side_n;
      int                    frames_n;
      int                    patch_len;
      int                    cand_total;
      int                    cut;
      int                    c;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_PATCH_SIDE;
      csr_ch.data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // One voxel per candidate: improvement, equal cost, cutoff at zero.
      reshape(1, 1);
      item = flat_voxel(8'h00, 8'hFF);
      item.cand_row   = '1;
      item.cand_col   = '1;
      item.cand_frame = '1;
      send_item(item);
      item = flat_voxel(8'hFF, 8'hFF);
      item.cand_row   = '0;
      item.cand_col   = '0;
      item.cand_frame = '0;
      send_item(item);
      send_item(flat_voxel(8'h07, 8'h07));
      item = make_load(COST_MAX);
      item.cand_row   = '1;
      item.cand_col   = '1;
      item.cand_frame = '1;
      send_item(item);
      send_item(flat_voxel(8'hFF, 8'h00));
      send_item(make_load('0));
      send_item(flat_voxel(8'h80, 8'h80));
      send_item(make_load(5));
      send_item(flat_voxel(8'h0A, 8'h0B));

      // Two rows of two: early exit after the first row, then a load that
      // restarts a candidate halfway through.
      reshape(2, 1);
      send_item(make_load(100));
      send_item(flat_voxel(8'h00, 8'hFF));
      send_item(flat_voxel(8'h00, 8'hFF));
      send_item(flat_voxel(8'h00, 8'h00));
      send_item(flat_voxel(8'h00, 8'h00));
      send_item(flat_voxel(8'h01, 8'h02));
      send_item(make_load(COST_MAX));
      repeat (4) send_item(flat_voxel(8'h03, 8'h05));

      // Shrinking the patch in the middle of a candidate lets the next voxel end it.
      reshape(3, 1);
      repeat (4) send_item(make_voxel(PIX_RANDOM));
      reshape(1, 1);
      send_item(make_voxel(PIX_NEAR));

      // Zero in both registers acts as a single voxel.
      reshape(0, 0);
      send_item(make_voxel(PIX_RANDOM));

      // Hold the result side off while the request side keeps pushing.
      reshape(1, 1);
      no_idle       <= 1'b1;
      hold_requests <= hold_requests + 1;
      repeat (40) send_item(make_voxel(pixel_mode_type'($urandom_range(0, 3))));

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 11))
            9: begin
               side_d   = CSR_DATA_W'($urandom_range(1, 2));
               frames_d = CSR_DATA_W'($urandom_range(3, 31));
            end
            10: begin
               side_d   = CSR_DATA_W'($urandom_range(4, 31));
               frames_d = CSR_DATA_W'($urandom_range(0, 1) | ($urandom_range(0, 1) << 4));
            end
            11: begin
               side_d   = CSR_DATA_W'($urandom_range(4, 6));
               frames_d = CSR_DATA_W'($urandom_range(0, 2));
            end
            default: begin
               side_d   = CSR_DATA_W'($urandom_range(0, 3));
               frames_d = CSR_DATA_W'($urandom_range(0, 2) | ($urandom_range(0, 1) << 4));
            end
         endcase
         reshape(side_d, frames_d);
         no_idle <= ($urandom_range(0, 3) == 0);

         side_n    = (side_d == 0) ? 1 : ((side_d > MAX_SIDE) ? MAX_SIDE : int'(side_d));
         frames_n  = int'(frames_d[FRAMES_CSR_W-1:0]);
         frames_n  = (frames_n == 0) ? 1 : ((frames_n > MAX_FRAMES) ? MAX_FRAMES : frames_n);
         patch_len = side_n * side_n * frames_n;
         cand_total = (patch_len >= 48) ? 1 : $urandom_range(1, 60 / patch_len);

         if ($urandom_range(0, 2) != 0) send_item(make_load(pick_cost(patch_len)));
         for (c = 0; c < cand_total; c++) begin
            mode = pixel_mode_type'($urandom_range(0, 3));
            cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, patch_len - 1) : patch_len;
            repeat (cut) send_item(make_voxel(mode));
            if (cut < patch_len) begin
               // A broken candidate either restarts on a load or is left
               // half done for the next patch shape.
               if ($urandom_range(0, 1) == 0) break;
               send_item(make_load(pick_cost(patch_len)));
            end else if ($urandom_range(0, 3) == 0) begin
               send_item(make_load(pick_cost(patch_len)));
            end
         end
      end

      drain();
      if (mismatch_count == 0 && matches_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pssd_pkg.sv
rtl/core/pssd_stream_if.sv
rtl/core/pssd_csr_if.sv
rtl/core/patch_ssd_best_match_update_unit.sv
tb/sv/best_match_checker.sv
tb/sv/tb_patch_ssd_best_match_update_unit.sv
